### src/wcp_pkg.sv
// ----------------------------------------------------------------------------
// wcp_pkg
// shared types, constants and the cosine table of the wall column projection
// ----------------------------------------------------------------------------
package wcp_pkg;

    localparam int TILE_UNITS     = 64;
    localparam int SCREEN_HEIGHT  = 512;
    localparam int TEXTURE_HEIGHT = 64;
    localparam int TEXTURE_COUNT  = 8;
    localparam int ANGLE_STEPS    = 4096;

    localparam int ANGLE_W   = $clog2(ANGLE_STEPS);
    localparam int TILE_W    = $clog2(TILE_UNITS);
    localparam int TEX_W     = 3;
    localparam int DIST_W    = 24;
    localparam int PLANE_W   = 12;
    localparam int HEIGHT_W  = 16;
    localparam int TOP_W     = 9;
    localparam int BOT_W     = 10;
    localparam int STEP_W    = 23;
    localparam int OFF_W     = 15;
    localparam int COS_W     = 17;
    localparam int QUARTER   = ANGLE_STEPS / 4;
    localparam int CIDX_W    = $clog2(QUARTER + 1);
    localparam int NUM_SHIFT = $clog2(TILE_UNITS) + 8;
    localparam int NUM_W     = PLANE_W + NUM_SHIFT;
    localparam int MID       = SCREEN_HEIGHT / 2;
    localparam int HDIV_N    = HEIGHT_W;
    localparam int SDIV_N    = STEP_W;
    localparam int SNUM_W    = $clog2(TEXTURE_HEIGHT) + 17;

    localparam logic [63:0] TWO_PI_Q28 = 64'd1686629713;

    typedef logic [COS_W-1:0] t_cos_tab [0:QUARTER];

    typedef struct packed {
        logic [TILE_W-1:0] col;
        logic [TEX_W-1:0]  idx;
    } t_side;

    typedef struct packed {
        logic [NUM_W-1:0]  num;
        logic [DIST_W-1:0] den;
        logic              sat;
        t_side             side;
    } t_hdiv;

    typedef struct packed {
        logic [HEIGHT_W-1:0] h;
        logic [TOP_W-1:0]    top;
        logic [BOT_W-1:0]    bot;
        logic [OFF_W-1:0]    off;
        t_side               side;
    } t_geom;

    function automatic t_cos_tab build_cos_table();
        t_cos_tab    tab;
        logic [63:0] t;
        logic [63:0] th;
        logic [63:0] u;
        logic [63:0] u2;
        logic [63:0] u3;
        logic [63:0] u4;
        logic [63:0] c;
        for (int i = 0; i <= QUARTER; i++) begin
            t  = 64'(i) * 64'(65536 / ANGLE_STEPS);
            th = (t * TWO_PI_Q28) >> 16;
            u  = (th * th) >> 28;
            u2 = (u * u) >> 28;
            u3 = (u2 * u) >> 28;
            u4 = (u3 * u) >> 28;
            c  = (64'd1 << 28) - u / 64'd2 + u2 / 64'd24 - u3 / 64'd720 + u4 / 64'd40320;
            c  = c >> 12;
            if (c > 64'd65536) begin
                c = 64'd65536;
            end
            tab[i] = c[COS_W-1:0];
        end
        return tab;
    endfunction

    localparam t_cos_tab COS_TABLE = build_cos_table();

endpackage

### src/wall_column_projection_core.sv
// ----------------------------------------------------------------------------
// wall_column_projection_core
// per column wall strip projection of a textured raycaster
// ----------------------------------------------------------------------------
// one ray hit beat in on the s_axis side gives one column beat out on m_axis
// s tdata: ray_distance, ray_angle, view_angle, hit_x, hit_y (low bit first)
// s tuser: hit_vertical, wall_kind
// m tdata: strip_height, wall_top, wall_bottom, texture_column,
//          texture_index, row_step, start_offset, zero pad
// i_cfg_we/i_cfg_wdata write plane_distance; write only while idle
// latency: 44 cycles, 4 cosine/correction stages, 16 height divider stages,
//   1 geometry stage, 23 row step divider stages; the last divider stage
//   drives the output directly
// throughput: one beat per cycle, set by the bit-per-stage dividers
// reset clears all valid bits and sets plane_distance to 693
// a stalled receiver freezes the whole pipeline; nothing is lost or repeated
// and o_s_axis_tready drops in the same cycle
// ----------------------------------------------------------------------------
module wall_column_projection_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [wcp_pkg::PLANE_W-1:0]   i_cfg_wdata,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // ray_distance, ray_angle, view_angle, hit_x, hit_y
    input  logic [79:0]                   i_s_axis_tdata,
    // hit_vertical, wall_kind
    input  logic [4:0]                    i_s_axis_tuser,
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // strip_height, wall_top, wall_bottom, texture_column, texture_index,
    // row_step, start_offset, pad
    output logic [87:0]                   o_m_axis_tdata
);

    logic [wcp_pkg::PLANE_W-1:0]   r_plane;
    logic                          en;
    logic                          cos_valid;
    wcp_pkg::t_hdiv                cos_data;
    logic                          h_valid;
    logic [wcp_pkg::HEIGHT_W-1:0]  h_val;
    wcp_pkg::t_side                h_side;
    logic                          r_g_valid;
    wcp_pkg::t_geom                r_g;
    wcp_pkg::t_geom                n_g;
    logic [wcp_pkg::HEIGHT_W-2:0]  n_half;
    logic [wcp_pkg::HEIGHT_W:0]    n_bot;
    logic                          s_valid;
    wcp_pkg::t_geom                s_geom;
    logic [wcp_pkg::STEP_W-1:0]    s_step;

    assign en              = !o_m_axis_tvalid || i_m_axis_tready;
    assign o_s_axis_tready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plane <= wcp_pkg::PLANE_W'(693);
        end else if (i_cfg_we) begin
            r_plane <= i_cfg_wdata;
        end
    end

    wcp_cos u_cos (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_en             (en),
        .i_valid          (i_s_axis_tvalid),
        .i_dist           (i_s_axis_tdata[23:0]),
        .i_ray_angle      (i_s_axis_tdata[35:24]),
        .i_view_angle     (i_s_axis_tdata[47:36]),
        .i_hit_vertical   (i_s_axis_tuser[0]),
        .i_hit_x          (i_s_axis_tdata[63:48]),
        .i_hit_y          (i_s_axis_tdata[79:64]),
        .i_wall_kind      (i_s_axis_tuser[4:1]),
        .i_plane_distance (r_plane),
        .o_valid          (cos_valid),
        .o_data           (cos_data)
    );

    wcp_hdiv u_hdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (cos_valid),
        .i_data  (cos_data),
        .o_valid (h_valid),
        .o_h     (h_val),
        .o_side  (h_side)
    );

    always_comb begin
        n_half   = h_val[wcp_pkg::HEIGHT_W-1:1];
        n_g.h    = h_val;
        n_g.side = h_side;
        n_g.top  = (n_half >= (wcp_pkg::HEIGHT_W-1)'(wcp_pkg::MID)) ? '0
                 : wcp_pkg::TOP_W'((wcp_pkg::HEIGHT_W-1)'(wcp_pkg::MID) - n_half);
        n_bot    = (wcp_pkg::HEIGHT_W+1)'(wcp_pkg::MID) + (wcp_pkg::HEIGHT_W+1)'(n_half);
        n_g.bot  = (n_bot > (wcp_pkg::HEIGHT_W+1)'(wcp_pkg::SCREEN_HEIGHT))
                 ? wcp_pkg::BOT_W'(wcp_pkg::SCREEN_HEIGHT) : n_bot[wcp_pkg::BOT_W-1:0];
        n_g.off  = (n_half > (wcp_pkg::HEIGHT_W-1)'(wcp_pkg::MID))
                 ? wcp_pkg::OFF_W'(n_half - (wcp_pkg::HEIGHT_W-1)'(wcp_pkg::MID)) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_valid <= 1'b0;
        end else if (en) begin
            r_g_valid <= h_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_g <= n_g;
        end
    end

    wcp_sdiv u_sdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_g_valid),
        .i_geom  (r_g),
        .o_valid (s_valid),
        .o_geom  (s_geom),
        .o_step  (s_step)
    );

    assign o_m_axis_tvalid = s_valid;
    assign o_m_axis_tdata  = {6'd0, s_geom.off, s_step, s_geom.side.idx, s_geom.side.col,
                              s_geom.bot, s_geom.top, s_geom.h};

endmodule

### src/wcp_cos.sv
// ----------------------------------------------------------------------------
// wcp_cos
// angle fold, cosine rom, fisheye correction and divider setup
// ----------------------------------------------------------------------------
module wcp_cos (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_valid,
    input  logic [wcp_pkg::DIST_W-1:0]        i_dist,
    input  logic [wcp_pkg::ANGLE_W-1:0]       i_ray_angle,
    input  logic [wcp_pkg::ANGLE_W-1:0]       i_view_angle,
    input  logic                              i_hit_vertical,
    input  logic [15:0]                       i_hit_x,
    input  logic [15:0]                       i_hit_y,
    input  logic [3:0]                        i_wall_kind,
    input  logic [wcp_pkg::PLANE_W-1:0]       i_plane_distance,
    output logic                              o_valid,
    output wcp_pkg::t_hdiv                    o_data
);

    logic [2:0]                     r_valid;
    logic [wcp_pkg::CIDX_W-1:0]     r1_idx;
    logic                           r1_neg;
    logic [wcp_pkg::DIST_W-1:0]     r1_dist;
    wcp_pkg::t_side                 r1_side;
    logic [wcp_pkg::COS_W-1:0]      r2_cos;
    logic                           r2_neg;
    logic [wcp_pkg::DIST_W-1:0]     r2_dist;
    wcp_pkg::t_side                 r2_side;
    logic [wcp_pkg::DIST_W-1:0]     r3_corr;
    logic                           r3_neg;
    logic [wcp_pkg::NUM_W-1:0]      r3_num;
    wcp_pkg::t_side                 r3_side;
    logic                           r_out_valid;
    wcp_pkg::t_hdiv                 r_out;

    logic [wcp_pkg::ANGLE_W-1:0]    n_d;
    logic [wcp_pkg::ANGLE_W:0]      n_t;
    logic                           n_neg;
    logic [wcp_pkg::DIST_W+wcp_pkg::COS_W-1:0] n_prod;
    logic [3:0]                     n_kind;

    always_comb begin
        n_d = i_ray_angle - i_view_angle;
        case (n_d[wcp_pkg::ANGLE_W-1 -: 2])
            2'd0: begin
                n_t   = {1'b0, n_d};
                n_neg = 1'b0;
            end
            2'd1: begin
                n_t   = (wcp_pkg::ANGLE_W+1)'(wcp_pkg::ANGLE_STEPS / 2) - {1'b0, n_d};
                n_neg = 1'b1;
            end
            2'd2: begin
                n_t   = {1'b0, n_d} - (wcp_pkg::ANGLE_W+1)'(wcp_pkg::ANGLE_STEPS / 2);
                n_neg = 1'b1;
            end
            default: begin
                n_t   = (wcp_pkg::ANGLE_W+1)'(wcp_pkg::ANGLE_STEPS) - {1'b0, n_d};
                n_neg = 1'b0;
            end
        endcase
        n_kind = i_wall_kind - 4'd1;
        n_prod = r2_dist * r2_cos;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else if (i_en) begin
            r_valid     <= {r_valid[1:0], i_valid};
            r_out_valid <= r_valid[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // fold to a quarter turn
            r1_idx        <= n_t[wcp_pkg::CIDX_W-1:0];
            r1_neg        <= n_neg;
            r1_dist       <= i_dist;
            r1_side.col   <= i_hit_vertical ? i_hit_y[wcp_pkg::TILE_W-1:0]
                                            : i_hit_x[wcp_pkg::TILE_W-1:0];
            r1_side.idx   <= n_kind[wcp_pkg::TEX_W-1:0];
            // rom read
            r2_cos        <= wcp_pkg::COS_TABLE[r1_idx];
            r2_neg        <= r1_neg;
            r2_dist       <= r1_dist;
            r2_side       <= r1_side;
            // corrected distance
            r3_corr       <= n_prod[16 +: wcp_pkg::DIST_W];
            r3_neg        <= r2_neg && (r2_cos != '0);
            r3_num        <= {i_plane_distance, {wcp_pkg::NUM_SHIFT{1'b0}}};
            r3_side       <= r2_side;
            // saturation check
            r_out.num     <= r3_num;
            r_out.den     <= r3_corr;
            r_out.sat     <= r3_neg || (r3_corr == '0) ||
                             (wcp_pkg::DIST_W'(r3_num[wcp_pkg::NUM_W-1:16]) >= r3_corr);
            r_out.side    <= r3_side;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

### src/wcp_hdiv.sv
// ----------------------------------------------------------------------------
// wcp_hdiv
// pipelined restoring divider for the strip height, one quotient bit a stage
// ----------------------------------------------------------------------------
module wcp_hdiv (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_valid,
    input  wcp_pkg::t_hdiv                    i_data,
    output logic                              o_valid,
    output logic [wcp_pkg::HEIGHT_W-1:0]      o_h,
    output wcp_pkg::t_side                    o_side
);

    localparam int N  = wcp_pkg::HDIV_N;
    localparam int SW = wcp_pkg::DIST_W + N;

    logic [N-1:0]                 r_valid;
    logic [wcp_pkg::NUM_W-1:0]    r_rem  [0:N-1];
    logic [wcp_pkg::DIST_W-1:0]   r_den  [0:N-1];
    logic [N-1:0]                 r_q    [0:N-1];
    logic                         r_sat  [0:N-1];
    wcp_pkg::t_side               r_side [0:N-1];

    logic [wcp_pkg::NUM_W-1:0]    s_rem  [0:N-1];
    logic [wcp_pkg::DIST_W-1:0]   s_den  [0:N-1];
    logic [N-1:0]                 s_q    [0:N-1];
    logic                         s_sat  [0:N-1];
    wcp_pkg::t_side               s_side [0:N-1];
    logic [wcp_pkg::NUM_W-1:0]    n_rem  [0:N-1];
    logic [N-1:0]                 n_q    [0:N-1];
    logic [SW-1:0]                n_sh   [0:N-1];

    always_comb begin
        s_rem[0]  = i_data.num;
        s_den[0]  = i_data.den;
        s_q[0]    = '0;
        s_sat[0]  = i_data.sat;
        s_side[0] = i_data.side;
        for (int k = 1; k < N; k++) begin
            s_rem[k]  = r_rem[k-1];
            s_den[k]  = r_den[k-1];
            s_q[k]    = r_q[k-1];
            s_sat[k]  = r_sat[k-1];
            s_side[k] = r_side[k-1];
        end
        for (int k = 0; k < N; k++) begin
            n_sh[k]  = SW'(s_den[k]) << (N - 1 - k);
            n_rem[k] = s_rem[k];
            n_q[k]   = s_q[k];
            if (SW'(s_rem[k]) >= n_sh[k]) begin
                n_rem[k]         = s_rem[k] - n_sh[k][wcp_pkg::NUM_W-1:0];
                n_q[k][N-1-k]    = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[N-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < N; k++) begin
                r_rem[k]  <= n_rem[k];
                r_den[k]  <= s_den[k];
                r_q[k]    <= n_q[k];
                r_sat[k]  <= s_sat[k];
                r_side[k] <= s_side[k];
            end
        end
    end

    assign o_valid = r_valid[N-1];
    assign o_h     = r_sat[N-1] ? '1 : r_q[N-1];
    assign o_side  = r_side[N-1];

endmodule

### src/wcp_sdiv.sv
// ----------------------------------------------------------------------------
// wcp_sdiv
// pipelined restoring divider for the texture row step
// ----------------------------------------------------------------------------
module wcp_sdiv (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_valid,
    input  wcp_pkg::t_geom                    i_geom,
    output logic                              o_valid,
    output wcp_pkg::t_geom                    o_geom,
    output logic [wcp_pkg::STEP_W-1:0]        o_step
);

    localparam int N  = wcp_pkg::SDIV_N;
    localparam int RW = wcp_pkg::SNUM_W;
    localparam int SW = wcp_pkg::HEIGHT_W + N;

    logic [N-1:0]            r_valid;
    logic [RW-1:0]           r_rem  [0:N-1];
    logic [N-1:0]            r_q    [0:N-1];
    wcp_pkg::t_geom          r_geom [0:N-1];

    logic [RW-1:0]           s_rem  [0:N-1];
    logic [N-1:0]            s_q    [0:N-1];
    wcp_pkg::t_geom          s_geom [0:N-1];
    logic [RW-1:0]           n_rem  [0:N-1];
    logic [N-1:0]            n_q    [0:N-1];
    logic [SW-1:0]           n_sh   [0:N-1];

    always_comb begin
        s_rem[0]  = RW'(wcp_pkg::TEXTURE_HEIGHT) << 16;
        s_q[0]    = '0;
        s_geom[0] = i_geom;
        for (int k = 1; k < N; k++) begin
            s_rem[k]  = r_rem[k-1];
            s_q[k]    = r_q[k-1];
            s_geom[k] = r_geom[k-1];
        end
        for (int k = 0; k < N; k++) begin
            n_sh[k]  = SW'(s_geom[k].h) << (N - 1 - k);
            n_rem[k] = s_rem[k];
            n_q[k]   = s_q[k];
            if (SW'(s_rem[k]) >= n_sh[k]) begin
                n_rem[k]      = s_rem[k] - n_sh[k][RW-1:0];
                n_q[k][N-1-k] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[N-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < N; k++) begin
                r_rem[k]  <= n_rem[k];
                r_q[k]    <= n_q[k];
                r_geom[k] <= s_geom[k];
            end
        end
    end

    assign o_valid = r_valid[N-1];
    assign o_geom  = r_geom[N-1];
    assign o_step  = (r_geom[N-1].h == '0) ? '0 : r_q[N-1];

endmodule

### src/wcp_checker.sv
// ----------------------------------------------------------------------------
// wcp_checker
// port level checks of the wall column projection core
// ----------------------------------------------------------------------------
module wcp_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [wcp_pkg::PLANE_W-1:0]   i_cfg_wdata,
    input  logic                          i_s_axis_tvalid,
    input  logic                          o_s_axis_tready,
    input  logic [79:0]                   i_s_axis_tdata,
    input  logic [4:0]                    i_s_axis_tuser,
    input  logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    input  logic [87:0]                   o_m_axis_tdata
);

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output beat right after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled beat changed");

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready == (!o_m_axis_tvalid || i_m_axis_tready))
        else $error("input ready does not follow output stall");

    a_rows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[24:16] <= 9'd256 &&
            o_m_axis_tdata[34:25] <= 10'd512 && o_m_axis_tdata[34:25] >= 10'd256)
        else $error("wall rows out of screen");

    a_zero_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[15:0] == 16'd0 |-> o_m_axis_tdata[66:44] == 23'd0)
        else $error("row step nonzero for empty strip");

    logic unused_in;
    assign unused_in = i_cfg_we ^ (^i_cfg_wdata) ^ i_s_axis_tvalid ^ (^i_s_axis_tdata)
                     ^ (^i_s_axis_tuser);

endmodule

bind wall_column_projection_core wcp_checker u_wcp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_cfg_we        (i_cfg_we),
    .i_cfg_wdata     (i_cfg_wdata),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tdata  (i_s_axis_tdata),
    .i_s_axis_tuser  (i_s_axis_tuser),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
